[rtl/core/pprj_pkg.sv]
// shared types and constants for the perspective projection residual block
package pprj_pkg;

	localparam int MAX_CONSTRAINTS = 256;
	localparam int CIDX_W          = 8;
	localparam int FRAC_BITS       = 16;
	localparam int NUM_WORDS       = 14;
	localparam int SLOT_W          = 4;
	localparam int WORD_W          = 32;

	// projected coordinate, product and accumulator widths
	localparam int PROD_W = 2 * WORD_W;
	localparam int SUM_W  = PROD_W + 3;
	localparam int P_W    = 49;
	localparam int SPLIT  = 24;
	localparam int PH_W   = P_W - SPLIT;
	localparam int PP_W   = WORD_W + SPLIT + 1;
	localparam int WW_W   = 2 * SPLIT;
	localparam int D_W    = 82;

	// divider: quotient bits kept, operand width, stages
	localparam int Q_W        = 34;
	localparam int DIV_W      = 96;
	localparam int DIV_STAGES = Q_W + 1;
	localparam int NUM_RES    = 8;

	// pipeline registers in front of the dividers, then dividers, then output
	localparam int PRE_STAGES = 6;
	localparam int NST        = PRE_STAGES + DIV_STAGES + 1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_TGT_X = 4'd12;
	localparam logic [SLOT_W-1:0] SLOT_TGT_Y = 4'd13;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t WORD_MAX = 32'sh7fffffff;
	localparam word_t WORD_MIN = 32'sh80000000;
	localparam logic signed [P_W-1:0] P_ONE = 49'sd65536;

	typedef struct packed {
		logic                  kind;
		logic [CIDX_W-1:0]     constraint_index;
		logic [SLOT_W-1:0]     word_slot;
		word_t                 word_value;
		word_t                 point_x;
		word_t                 point_y;
		word_t                 point_z;
	} pprj_in_t;

	typedef struct packed {
		word_t residual_x;
		word_t residual_y;
		word_t du_dvx;
		word_t du_dvy;
		word_t du_dvz;
		word_t dv_dvx;
		word_t dv_dvy;
		word_t dv_dvz;
		logic  clipped;
		logic  saturated;
	} pprj_out_t;

	// what travels beside the dividers
	typedef struct packed {
		logic                 clip;
		word_t                tgt_x;
		word_t                tgt_y;
		logic [NUM_RES-1:0]   neg;
	} pprj_side_t;

endpackage

[rtl/core/pprj_in_if.sv]
// input channel interface: load and evaluate items
interface pprj_in_if import pprj_pkg::*; ();
	logic     valid;
	logic     ready;
	pprj_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/core/pprj_out_if.sv]
// output channel interface: residual and jacobian results
interface pprj_out_if import pprj_pkg::*; ();
	logic      valid;
	logic      ready;
	pprj_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/core/pprj_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module pprj_div import pprj_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	logic [DIV_W-1:0] rem_q [DIV_STAGES];
	logic [DIV_W-1:0] den_q [DIV_STAGES];
	logic [Q_W-1:0]   nb_q  [DIV_STAGES];
	logic [Q_W-1:0]   quo_q [DIV_STAGES];
	logic             ovf_q [DIV_STAGES];

	// quotient of Q_W bits exists only if the top part is below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= DIV_W'(num[DIV_W-1:Q_W]);
			nb_q[0]  <= num[Q_W-1:0];
			den_q[0] <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= DIV_W'(num[DIV_W-1:Q_W]) >= den;
		end
	end

	for (genvar i = 1; i < DIV_STAGES; i++) begin : g_stage
		logic [DIV_W:0]   cat;
		logic [DIV_W+1:0] dif;
		logic             ge;

		assign cat = {rem_q[i-1], nb_q[i-1][Q_W-1]};
		assign dif = {1'b0, cat} - {2'b00, den_q[i-1]};
		assign ge  = ~dif[DIV_W+1];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? dif[DIV_W-1:0] : cat[DIV_W-1:0];
				nb_q[i]  <= {nb_q[i-1][Q_W-2:0], 1'b0};
				den_q[i] <= den_q[i-1];
				quo_q[i] <= {quo_q[i-1][Q_W-2:0], ge};
				ovf_q[i] <= ovf_q[i-1];
			end
		end
	end

	assign quo = quo_q[DIV_STAGES-1];
	assign ovf = ovf_q[DIV_STAGES-1];

endmodule

[rtl/core/perspective_projection_residual.sv]
// an evaluate item passes the pre-divider stages, the dividers and the output register
// throughput: one item per cycle while the skid register is empty; a load item writes
// the table in its transfer cycle; the 35-stage divider pipelines give one quotient bit
// per stage; a skid register at the output takes a refused result, and the pipeline
// stalls only while it holds one; reset clears the stage valid bits and the skid valid
// bit; table entries are undefined until loaded
module perspective_projection_residual import pprj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pprj_in_if.sink     cmd,
	pprj_out_if.source  res
);

	logic              en;
	logic              take;
	logic [NST:1]      vld_q;
	logic [NUM_WORDS-1:0] wr_en;

	// stage 1: table read and point
	word_t rd_s1 [NUM_WORDS];
	word_t v_s1 [3];

	// stage 2: matrix times point products
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	word_t off_s2 [3];
	word_t m_s2 [3][3];
	word_t tgt_s2 [2];

	// stage 3: projected x, y, w
	logic signed [SUM_W-1:0] sum_c [3];
	logic signed [P_W-1:0]   p_s3 [3];
	word_t m_s3 [3][3];
	word_t tgt_s3 [2];
	logic  clip_s3;

	// stage 4: partial products of the jacobian terms and of w squared
	logic signed [SPLIT:0]  plo_c [3];
	logic signed [PH_W-1:0] phi_c [3];
	logic signed [PP_W-1:0] ah_s4 [2][3];
	logic signed [PP_W-1:0] al_s4 [2][3];
	logic signed [PP_W-1:0] bh_s4 [2][3];
	logic signed [PP_W-1:0] bl_s4 [2][3];
	logic [WW_W-1:0]        hh_s4, hl_s4, ll_s4;
	logic signed [P_W-1:0]  p_s4 [3];
	word_t tgt_s4 [2];
	logic  clip_s4;

	// stage 5: jacobian numerators and w squared
	logic signed [D_W-1:0]  d_s5 [2][3];
	logic [DIV_W-1:0]       w2_s5;
	logic signed [P_W-1:0]  p_s5 [3];
	word_t tgt_s5 [2];
	logic  clip_s5;

	// stage 6: unsigned divider operands
	logic [D_W-1:0]     dmag_c [2][3];
	logic [P_W-1:0]     pmag_c [2];
	logic [DIV_W-1:0]   num_s6 [NUM_RES];
	logic [DIV_W-1:0]   jden_s6;
	logic [DIV_W-1:0]   rden_s6;
	pprj_side_t         side_s6;

	pprj_side_t         side_q [DIV_STAGES];
	logic [Q_W-1:0]     quo [NUM_RES];
	logic               ovf [NUM_RES];

	// output
	word_t              val_c [NUM_RES];
	logic [NUM_RES-1:0] satv_c;
	logic signed [Q_W+1:0] sq_c [2];
	logic signed [Q_W+2:0] rdiff_c [2];
	pprj_out_t          res_c;
	pprj_out_t          out_s42;
	pprj_out_t          skid_q;
	logic               skid_v_q;

	// the whole pipeline moves unless the skid register holds a result
	assign en        = ~skid_v_q;
	assign cmd.ready = en;
	assign take      = cmd.valid & en;

	always_comb begin
		for (int s = 0; s < NUM_WORDS; s++) begin
			wr_en[s] = take && cmd.data.kind == KIND_LOAD && cmd.data.word_slot == SLOT_W'(s);
		end
	end

	for (genvar s = 0; s < NUM_WORDS; s++) begin : g_bank
		word_t bank [MAX_CONSTRAINTS];

		always_ff @(posedge clk) begin
			if (wr_en[s]) begin
				bank[cmd.data.constraint_index] <= cmd.data.word_value;
			end
			if (en) begin
				rd_s1[s] <= bank[cmd.data.constraint_index];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q[1] <= take && cmd.data.kind == KIND_EVAL;
			for (int k = 2; k <= NST; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= cmd.data.point_x;
			v_s1[1] <= cmd.data.point_y;
			v_s1[2] <= cmd.data.point_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				off_s2[r] <= rd_s1[r*4+3];
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= rd_s1[r*4+c] * v_s1[c];
					m_s2[r][c]    <= rd_s1[r*4+c];
				end
			end
			tgt_s2[0] <= rd_s1[SLOT_TGT_X];
			tgt_s2[1] <= rd_s1[SLOT_TGT_Y];
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = (SUM_W'(off_s2[r]) <<< FRAC_BITS) + SUM_W'(prod_s2[r][0])
				+ SUM_W'(prod_s2[r][1]) + SUM_W'(prod_s2[r][2]);
		end
	end

	// taking the bits above the fraction floors toward minus infinity
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				p_s3[r] <= sum_c[r][FRAC_BITS +: P_W];
			end
			clip_s3 <= $signed(sum_c[2][FRAC_BITS +: P_W]) < P_ONE;
			m_s3    <= m_s2;
			tgt_s3  <= tgt_s2;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			plo_c[r] = {1'b0, p_s3[r][SPLIT-1:0]};
			phi_c[r] = p_s3[r][P_W-1:SPLIT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 3; c++) begin
					ah_s4[r][c] <= m_s3[r][c] * phi_c[2];
					al_s4[r][c] <= m_s3[r][c] * plo_c[2];
					bh_s4[r][c] <= m_s3[2][c] * phi_c[r];
					bl_s4[r][c] <= m_s3[2][c] * plo_c[r];
				end
			end
			// w is positive whenever the result is used
			hh_s4   <= p_s3[2][2*SPLIT-1:SPLIT] * p_s3[2][2*SPLIT-1:SPLIT];
			hl_s4   <= p_s3[2][2*SPLIT-1:SPLIT] * p_s3[2][SPLIT-1:0];
			ll_s4   <= p_s3[2][SPLIT-1:0] * p_s3[2][SPLIT-1:0];
			p_s4    <= p_s3;
			tgt_s4  <= tgt_s3;
			clip_s4 <= clip_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 3; c++) begin
					d_s5[r][c] <= (D_W'(ah_s4[r][c]) <<< SPLIT) + D_W'(al_s4[r][c])
						- (D_W'(bh_s4[r][c]) <<< SPLIT) - D_W'(bl_s4[r][c]);
				end
			end
			w2_s5   <= (DIV_W'(hh_s4) << (2*SPLIT)) + (DIV_W'(hl_s4) << (SPLIT+1))
				+ DIV_W'(ll_s4);
			p_s5    <= p_s4;
			tgt_s5  <= tgt_s4;
			clip_s5 <= clip_s4;
		end
	end

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			pmag_c[r] = p_s5[r][P_W-1] ? P_W'(-p_s5[r]) : P_W'(p_s5[r]);
			for (int c = 0; c < 3; c++) begin
				dmag_c[r][c] = d_s5[r][c][D_W-1] ? D_W'(-d_s5[r][c]) : D_W'(d_s5[r][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				num_s6[r]      <= DIV_W'(pmag_c[r]) << FRAC_BITS;
				side_s6.neg[r] <= p_s5[r][P_W-1];
				for (int c = 0; c < 3; c++) begin
					num_s6[2+r*3+c]      <= DIV_W'(dmag_c[r][c]) << FRAC_BITS;
					side_s6.neg[2+r*3+c] <= d_s5[r][c][D_W-1];
				end
			end
			jden_s6       <= w2_s5;
			rden_s6       <= DIV_W'(p_s5[2][P_W-2:0]);
			side_s6.clip  <= clip_s5;
			side_s6.tgt_x <= tgt_s5[0];
			side_s6.tgt_y <= tgt_s5[1];
		end
	end

	for (genvar k = 0; k < NUM_RES; k++) begin : g_div
		pprj_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s6[k]),
			.den ((k < 2) ? rden_s6 : jden_s6),
			.quo (quo[k]),
			.ovf (ovf[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s6;
			for (int k = 1; k < DIV_STAGES; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			sq_c[r] = side_q[DIV_STAGES-1].neg[r] ? -$signed({2'b00, quo[r]})
				: $signed({2'b00, quo[r]});
			rdiff_c[r] = (Q_W+3)'(sq_c[r]) - (Q_W+3)'(r == 0 ? side_q[DIV_STAGES-1].tgt_x
				: side_q[DIV_STAGES-1].tgt_y);
			// out of range when the bits above the sign bit disagree
			if (ovf[r] || (rdiff_c[r][Q_W+2:WORD_W-1] != '0
					&& rdiff_c[r][Q_W+2:WORD_W-1] != '1)) begin
				satv_c[r] = 1'b1;
				if (ovf[r]) begin
					val_c[r] = side_q[DIV_STAGES-1].neg[r] ? WORD_MIN : WORD_MAX;
				end else begin
					val_c[r] = rdiff_c[r][Q_W+2] ? WORD_MIN : WORD_MAX;
				end
			end else begin
				satv_c[r] = 1'b0;
				val_c[r]  = rdiff_c[r][WORD_W-1:0];
			end
		end
		for (int k = 2; k < NUM_RES; k++) begin
			if (side_q[DIV_STAGES-1].neg[k]) begin
				// magnitude two to the 31 still fits as the most negative word
				if (!ovf[k] && (quo[k][Q_W-1:WORD_W-1] == '0
						|| (quo[k][Q_W-1:WORD_W-1] == 3'b001 && quo[k][WORD_W-2:0] == '0))) begin
					satv_c[k] = 1'b0;
					val_c[k]  = -quo[k][WORD_W-1:0];
				end else begin
					satv_c[k] = 1'b1;
					val_c[k]  = WORD_MIN;
				end
			end else begin
				if (!ovf[k] && quo[k][Q_W-1:WORD_W-1] == '0) begin
					satv_c[k] = 1'b0;
					val_c[k]  = quo[k][WORD_W-1:0];
				end else begin
					satv_c[k] = 1'b1;
					val_c[k]  = WORD_MAX;
				end
			end
		end

		if (side_q[DIV_STAGES-1].clip) begin
			res_c = '0;
			res_c.clipped = 1'b1;
		end else begin
			res_c.residual_x = val_c[0];
			res_c.residual_y = val_c[1];
			res_c.du_dvx     = val_c[2];
			res_c.du_dvy     = val_c[3];
			res_c.du_dvz     = val_c[4];
			res_c.dv_dvx     = val_c[5];
			res_c.dv_dvy     = val_c[6];
			res_c.dv_dvz     = val_c[7];
			res_c.clipped    = 1'b0;
			res_c.saturated  = |satv_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s42 <= res_c;
		end
	end

	// a refused result moves aside into the skid register, and the pipeline stalls while it is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld_q[NST] && !res.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && vld_q[NST] && !res.ready) begin
			skid_q <= out_s42;
		end
	end

	assign res.valid = skid_v_q | vld_q[NST];
	assign res.data  = skid_v_q ? skid_q : out_s42;

endmodule
